/* rtl/tng_pkg.sv */
// ----------------------------------------------------------------------------
// tng_pkg: shared types and constants of the triangle normal glyph block
// Stage records of the square root and divider sections of the pipeline.
// ----------------------------------------------------------------------------
package tng_pkg;

  localparam logic [31:0] SCALE_RESET = 32'd65536;
  localparam int          SQ_STAGES   = 31;  // one root bit per stage
  localparam int          DV_STAGES   = 33;  // one quotient bit per stage

  // square root section
  typedef struct packed {
    logic             vld;
    logic [2:0][31:0] cq;     // |a+b+c| rounded divide by three per axis
    logic [2:0]       cneg;
    logic [2:0]       neg;    // sign of the scaled normal per axis
    logic             degen;
    logic [2:0][61:0] prod;   // |v| * |scale|
    logic [63:0]      rem;
    logic [30:0]      root;
  } sq_t;

  // divider section
  typedef struct packed {
    logic             vld;
    logic [2:0][31:0] cq;
    logic [2:0]       cneg;
    logic [2:0]       neg;
    logic             degen;
    logic [2:0][63:0] nrem;
    logic [2:0][32:0] q;
    logic [30:0]      len;
  } dv_t;

endpackage

/* rtl/triangle_normal_glyph.sv */
// ----------------------------------------------------------------------------
// triangle_normal_glyph: face normal glyph of one triangle
// Centroid and centroid plus scaled unit normal in signed Q16.16, saturated.
// ----------------------------------------------------------------------------
//  channel | ports                          | handshake
//  --------+--------------------------------+-----------------------------
//  in      | in_is_triangle, in_vertex_*    | start & !busy
//  out     | out_start_*, out_end_*, flags  | out_valid, one cycle strobe
//  cfg     | cfg_wdata (scale_factor)       | cfg_we
//
// one request per cycle; a request passes stages a to i, the 31 stage square
// root, stage p, the 33 stage divider and the output register to out_valid;
// root and divider give one result bit per stage; busy stays low, nothing ever holds the pipe
// non-triangle requests travel as bubbles and give no strobe
// synchronous reset clears the stage valid bits and loads scale 1.0
module triangle_normal_glyph (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  logic               in_is_triangle,
  input  logic signed [31:0] in_vertex_a_x,
  input  logic signed [31:0] in_vertex_a_y,
  input  logic signed [31:0] in_vertex_a_z,
  input  logic signed [31:0] in_vertex_b_x,
  input  logic signed [31:0] in_vertex_b_y,
  input  logic signed [31:0] in_vertex_b_z,
  input  logic signed [31:0] in_vertex_c_x,
  input  logic signed [31:0] in_vertex_c_y,
  input  logic signed [31:0] in_vertex_c_z,
  output logic               out_valid,
  output logic signed [31:0] out_start_x,
  output logic signed [31:0] out_start_y,
  output logic signed [31:0] out_start_z,
  output logic signed [31:0] out_end_x,
  output logic signed [31:0] out_end_y,
  output logic signed [31:0] out_end_z,
  output logic               out_degenerate,
  output logic               out_saturated,
  input  logic               cfg_we,
  input  logic [31:0]        cfg_wdata
);

  localparam int LAT = 11 + tng_pkg::SQ_STAGES + tng_pkg::DV_STAGES;

  logic [31:0] scale_r;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scale_r <= tng_pkg::SCALE_RESET;
    end else if (cfg_we) begin
      scale_r <= cfg_wdata;
    end
  end

  // stage a: sums and edges
  logic [2:0][31:0] va, vb, vc;
  logic             a_vld_r;
  logic [2:0][33:0] a_s_r;
  logic [2:0][32:0] a_e1_r, a_e2_r;

  assign va = {in_vertex_a_z, in_vertex_a_y, in_vertex_a_x};
  assign vb = {in_vertex_b_z, in_vertex_b_y, in_vertex_b_x};
  assign vc = {in_vertex_c_z, in_vertex_c_y, in_vertex_c_x};

  always_ff @(posedge clk) begin
    if (!rst_n) a_vld_r <= 1'b0;
    else        a_vld_r <= start & ~busy & in_is_triangle;
    for (int j = 0; j < 3; j++) begin
      a_s_r[j]  <= {{2{va[j][31]}}, va[j]} + {{2{vb[j][31]}}, vb[j]}
                 + {{2{vc[j][31]}}, vc[j]};
      a_e1_r[j] <= {vb[j][31], vb[j]} - {va[j][31], va[j]};
      a_e2_r[j] <= {vc[j][31], vc[j]} - {va[j][31], va[j]};
    end
  end

  // stage b: centroid magnitude, edges brought into 32 bits
  logic             b_vld_r;
  logic [2:0][32:0] b_cmag_r;
  logic [2:0]       b_cneg_r;
  logic [2:0][31:0] b_d1_r, b_d2_r;
  logic [2:0][32:0] m1, m2;
  logic [2:0][33:0] sabs;
  logic             big;

  always_comb begin
    big = 1'b0;
    for (int j = 0; j < 3; j++) begin
      m1[j]   = a_e1_r[j][32] ? 33'(-a_e1_r[j]) : a_e1_r[j];
      m2[j]   = a_e2_r[j][32] ? 33'(-a_e2_r[j]) : a_e2_r[j];
      sabs[j] = a_s_r[j][33] ? 34'(-a_s_r[j]) : a_s_r[j];
      big     = big | m1[j][32] | m1[j][31] | m2[j][32] | m2[j][31];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) b_vld_r <= 1'b0;
    else        b_vld_r <= a_vld_r;
    for (int j = 0; j < 3; j++) begin
      b_cmag_r[j] <= sabs[j][32:0] + 33'd1;
      b_cneg_r[j] <= a_s_r[j][33];
      b_d1_r[j]   <= a_e1_r[j][32] ? 32'(-(big ? (m1[j] >> 1) : m1[j]))
                                   : 32'(big ? (m1[j] >> 1) : m1[j]);
      b_d2_r[j]   <= a_e2_r[j][32] ? 32'(-(big ? (m2[j] >> 1) : m2[j]))
                                   : 32'(big ? (m2[j] >> 1) : m2[j]);
    end
  end

  // stage c: cross product terms
  // x = h * 2^17 + l, so x / 3 = h * 43690 + (2h + l) / 3
  logic             c_vld_r;
  logic [2:0][31:0] c_cq_hi_r;
  logic [2:0][17:0] c_cy_r;
  logic [2:0]       c_cneg_r;
  logic [5:0][63:0] c_p_r;

  always_ff @(posedge clk) begin
    if (!rst_n) c_vld_r <= 1'b0;
    else        c_vld_r <= b_vld_r;
    for (int j = 0; j < 3; j++) begin
      c_cq_hi_r[j] <= 32'(b_cmag_r[j][32:17]) * 32'd43690;
      c_cy_r[j]    <= {1'b0, b_cmag_r[j][32:17], 1'b0} + {1'b0, b_cmag_r[j][16:0]};
    end
    c_cneg_r <= b_cneg_r;
    c_p_r[0] <= $signed(b_d1_r[1]) * $signed(b_d2_r[2]);
    c_p_r[1] <= $signed(b_d1_r[2]) * $signed(b_d2_r[1]);
    c_p_r[2] <= $signed(b_d1_r[2]) * $signed(b_d2_r[0]);
    c_p_r[3] <= $signed(b_d1_r[0]) * $signed(b_d2_r[2]);
    c_p_r[4] <= $signed(b_d1_r[0]) * $signed(b_d2_r[1]);
    c_p_r[5] <= $signed(b_d1_r[1]) * $signed(b_d2_r[0]);
  end

  // stage d: normal, centroid quotient
  // y / 3 for y < 2^19 is (y * 349526) >> 20
  logic             d_vld_r;
  logic [2:0][31:0] d_cq_r;
  logic [2:0]       d_cneg_r;
  logic [2:0][63:0] d_n_r;

  always_ff @(posedge clk) begin
    if (!rst_n) d_vld_r <= 1'b0;
    else        d_vld_r <= c_vld_r;
    d_cneg_r <= c_cneg_r;
    for (int j = 0; j < 3; j++) begin
      d_cq_r[j] <= c_cq_hi_r[j] + 32'((38'(c_cy_r[j]) * 38'd349526) >> 20);
      d_n_r[j]  <= c_p_r[2*j] - c_p_r[2*j+1];
    end
  end

  // stage e: magnitudes
  logic             e_vld_r;
  logic [2:0][31:0] e_cq_r;
  logic [2:0]       e_cneg_r;
  logic [2:0][62:0] e_vm_r;
  logic [2:0]       e_nneg_r;
  logic [62:0]      e_or_r;
  logic [2:0][63:0] nabs;

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      nabs[j] = d_n_r[j][63] ? 64'(-d_n_r[j]) : d_n_r[j];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) e_vld_r <= 1'b0;
    else        e_vld_r <= d_vld_r;
    e_cq_r   <= d_cq_r;
    e_cneg_r <= d_cneg_r;
    for (int j = 0; j < 3; j++) begin
      e_vm_r[j]   <= nabs[j][62:0];
      e_nneg_r[j] <= d_n_r[j][63];
    end
    e_or_r <= nabs[0][62:0] | nabs[1][62:0] | nabs[2][62:0];
  end

  // stage f: leading one of the largest component
  logic             f_vld_r;
  logic [2:0][31:0] f_cq_r;
  logic [2:0]       f_cneg_r;
  logic [2:0][62:0] f_vm_r;
  logic [2:0]       f_nneg_r;
  logic [5:0]       f_pos_r;
  logic             f_degen_r;
  logic [5:0]       pos;

  always_comb begin
    pos = '0;
    for (int b = 0; b < 63; b++) begin
      if (e_or_r[b]) pos = 6'(b);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) f_vld_r <= 1'b0;
    else        f_vld_r <= e_vld_r;
    f_cq_r    <= e_cq_r;
    f_cneg_r  <= e_cneg_r;
    f_vm_r    <= e_vm_r;
    f_nneg_r  <= e_nneg_r;
    f_pos_r   <= pos;
    f_degen_r <= (e_or_r == '0);
  end

  // stage g: normalize so the largest component sits in [2^29, 2^30)
  logic             g_vld_r;
  logic [2:0][31:0] g_cq_r;
  logic [2:0]       g_cneg_r;
  logic [2:0][29:0] g_v_r;
  logic [2:0]       g_nneg_r;
  logic             g_degen_r;
  logic             shr;
  logic [5:0]       sh;

  assign shr = (f_pos_r >= 6'd30);
  assign sh  = shr ? (f_pos_r - 6'd29) : (6'd29 - f_pos_r);

  always_ff @(posedge clk) begin
    if (!rst_n) g_vld_r <= 1'b0;
    else        g_vld_r <= f_vld_r;
    g_cq_r    <= f_cq_r;
    g_cneg_r  <= f_cneg_r;
    g_nneg_r  <= f_nneg_r;
    g_degen_r <= f_degen_r;
    for (int j = 0; j < 3; j++) begin
      g_v_r[j] <= shr ? 30'(f_vm_r[j] >> sh) : 30'(f_vm_r[j] << sh);
    end
  end

  // stage h: squares and scaled components
  logic             h_vld_r;
  logic [2:0][31:0] h_cq_r;
  logic [2:0]       h_cneg_r;
  logic [2:0]       h_neg_r;
  logic             h_degen_r;
  logic [2:0][59:0] h_sq_r;
  logic [2:0][61:0] h_prod_r;
  logic [31:0]      smag;

  assign smag = scale_r[31] ? 32'(-scale_r) : scale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) h_vld_r <= 1'b0;
    else        h_vld_r <= g_vld_r;
    h_cq_r    <= g_cq_r;
    h_cneg_r  <= g_cneg_r;
    h_degen_r <= g_degen_r;
    for (int j = 0; j < 3; j++) begin
      h_neg_r[j]  <= g_nneg_r[j] ^ scale_r[31];
      h_sq_r[j]   <= 60'(g_v_r[j]) * 60'(g_v_r[j]);
      h_prod_r[j] <= 62'(g_v_r[j]) * 62'(smag);
    end
  end

  // stage i: sum of squares
  logic             i_vld_r;
  logic [2:0][31:0] i_cq_r;
  logic [2:0]       i_cneg_r;
  logic [2:0]       i_neg_r;
  logic             i_degen_r;
  logic [2:0][61:0] i_prod_r;
  logic [61:0]      i_sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) i_vld_r <= 1'b0;
    else        i_vld_r <= h_vld_r;
    i_cq_r    <= h_cq_r;
    i_cneg_r  <= h_cneg_r;
    i_neg_r   <= h_neg_r;
    i_degen_r <= h_degen_r;
    i_prod_r  <= h_prod_r;
    i_sum_r   <= 62'(h_sq_r[0]) + 62'(h_sq_r[1]) + 62'(h_sq_r[2]);
  end

  // square root, one root bit per stage, msb first
  tng_pkg::sq_t q_in  [tng_pkg::SQ_STAGES];
  tng_pkg::sq_t q_nxt [tng_pkg::SQ_STAGES];
  tng_pkg::sq_t q_r   [tng_pkg::SQ_STAGES];

  always_comb begin
    q_in[0].vld   = i_vld_r;
    q_in[0].cq    = i_cq_r;
    q_in[0].cneg  = i_cneg_r;
    q_in[0].neg   = i_neg_r;
    q_in[0].degen = i_degen_r;
    q_in[0].prod  = i_prod_r;
    q_in[0].rem   = 64'(i_sum_r);
    q_in[0].root  = '0;
  end

  for (genvar k = 0; k < tng_pkg::SQ_STAGES; k++) begin : g_sq
    localparam int B = tng_pkg::SQ_STAGES - 1 - k;
    logic [63:0] trial;

    if (k > 0) begin : g_link
      assign q_in[k] = q_r[k-1];
    end

    // (r + 2^B)^2 - r^2 = r * 2^(B+1) + 2^(2B)
    assign trial = (64'(q_in[k].root) << (B + 1)) | (64'd1 << (2 * B));

    always_comb begin
      q_nxt[k] = q_in[k];
      if (q_in[k].rem >= trial) begin
        q_nxt[k].rem     = q_in[k].rem - trial;
        q_nxt[k].root[B] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) q_r[k].vld <= 1'b0;
      else        q_r[k].vld <= q_nxt[k].vld;
      q_r[k].cq    <= q_nxt[k].cq;
      q_r[k].cneg  <= q_nxt[k].cneg;
      q_r[k].neg   <= q_nxt[k].neg;
      q_r[k].degen <= q_nxt[k].degen;
      q_r[k].prod  <= q_nxt[k].prod;
      q_r[k].rem   <= q_nxt[k].rem;
      q_r[k].root  <= q_nxt[k].root;
    end
  end

  // stage p: rounding offset of half the length
  tng_pkg::sq_t sq_last;
  logic             p_vld_r;
  logic [2:0][31:0] p_cq_r;
  logic [2:0]       p_cneg_r;
  logic [2:0]       p_neg_r;
  logic             p_degen_r;
  logic [2:0][63:0] p_nrem_r;
  logic [30:0]      p_len_r;

  assign sq_last = q_r[tng_pkg::SQ_STAGES-1];

  always_ff @(posedge clk) begin
    if (!rst_n) p_vld_r <= 1'b0;
    else        p_vld_r <= sq_last.vld;
    p_cq_r    <= sq_last.cq;
    p_cneg_r  <= sq_last.cneg;
    p_neg_r   <= sq_last.neg;
    p_degen_r <= sq_last.degen;
    p_len_r   <= sq_last.root;
    for (int j = 0; j < 3; j++) begin
      p_nrem_r[j] <= 64'(sq_last.prod[j]) + 64'(sq_last.root >> 1);
    end
  end

  // restoring divide by the length
  tng_pkg::dv_t v_in  [tng_pkg::DV_STAGES];
  tng_pkg::dv_t v_nxt [tng_pkg::DV_STAGES];
  tng_pkg::dv_t v_r   [tng_pkg::DV_STAGES];

  always_comb begin
    v_in[0].vld   = p_vld_r;
    v_in[0].cq    = p_cq_r;
    v_in[0].cneg  = p_cneg_r;
    v_in[0].neg   = p_neg_r;
    v_in[0].degen = p_degen_r;
    v_in[0].nrem  = p_nrem_r;
    v_in[0].q     = '0;
    v_in[0].len   = p_len_r;
  end

  for (genvar k = 0; k < tng_pkg::DV_STAGES; k++) begin : g_dv
    localparam int B = tng_pkg::DV_STAGES - 1 - k;
    logic [63:0] dsr;

    if (k > 0) begin : g_link
      assign v_in[k] = v_r[k-1];
    end

    assign dsr = 64'(v_in[k].len) << B;

    always_comb begin
      v_nxt[k] = v_in[k];
      for (int j = 0; j < 3; j++) begin
        if (v_in[k].nrem[j] >= dsr) begin
          v_nxt[k].nrem[j] = v_in[k].nrem[j] - dsr;
          v_nxt[k].q[j][B] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) v_r[k].vld <= 1'b0;
      else        v_r[k].vld <= v_nxt[k].vld;
      v_r[k].cq    <= v_nxt[k].cq;
      v_r[k].cneg  <= v_nxt[k].cneg;
      v_r[k].neg   <= v_nxt[k].neg;
      v_r[k].degen <= v_nxt[k].degen;
      v_r[k].nrem  <= v_nxt[k].nrem;
      v_r[k].q     <= v_nxt[k].q;
      v_r[k].len   <= v_nxt[k].len;
    end
  end

  // output stage: end point with saturation
  tng_pkg::dv_t     dv_last;
  logic [2:0][33:0] cen, comp;
  logic [2:0][34:0] endw;
  logic [2:0][31:0] endv;
  logic [2:0]       clip;

  assign dv_last = v_r[tng_pkg::DV_STAGES-1];

  always_comb begin
    for (int j = 0; j < 3; j++) begin
      cen[j]  = dv_last.cneg[j] ? 34'(-{2'b0, dv_last.cq[j]}) : {2'b0, dv_last.cq[j]};
      comp[j] = dv_last.neg[j] ? 34'(-{1'b0, dv_last.q[j]}) : {1'b0, dv_last.q[j]};
      endw[j] = {cen[j][33], cen[j]} + {comp[j][33], comp[j]};
      clip[j] = ~dv_last.degen & (endw[j][34:31] != {4{endw[j][34]}});
      if (dv_last.degen) begin
        endv[j] = cen[j][31:0];
      end else if (clip[j]) begin
        endv[j] = endw[j][34] ? 32'h8000_0000 : 32'h7fff_ffff;
      end else begin
        endv[j] = endw[j][31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) out_valid <= 1'b0;
    else        out_valid <= dv_last.vld;
    out_start_x    <= cen[0][31:0];
    out_start_y    <= cen[1][31:0];
    out_start_z    <= cen[2][31:0];
    out_end_x      <= endv[0];
    out_end_y      <= endv[1];
    out_end_z      <= endv[2];
    out_degenerate <= dv_last.degen;
    out_saturated  <= |clip;
  end

  // a strobe only for a triangle request accepted earlier
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy && in_is_triangle, LAT))
    else $error("result without a matching triangle request");

  a_degen_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> out_end_x == out_start_x &&
      out_end_y == out_start_y && out_end_z == out_start_z)
    else $error("degenerate glyph with nonzero length");

  a_degen_sat: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_degenerate |-> !out_saturated)
    else $error("degenerate glyph flagged saturated");

endmodule
